// File: hdl/nsw_pkg.sv
package nsw_pkg;

    localparam int PEND_W   = 8;
    localparam int PCT_W    = 7;
    localparam int SHARES_W = 56;
    localparam int COUNT_W  = 4;
    localparam int AVG_W    = 32;
    localparam int SHARE_W  = 31;
    localparam int WIN_W    = 3;
    localparam int PCT_FULL = 100;

    // One quotient bit and one multiplier bit are produced per step.
    localparam int DIV_STEPS = 32;

    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [31:0] NVS_BETA   = 32'd1073742;
    localparam logic [31:0] WEIGHT_MAX = '1;

    // Decay factor (1 - beta) in Q2.30, pre-scaled by 4 so that a 32-step
    // serial multiply ending in a 32-bit right shift gives the Q2.30 product.
    localparam logic [31:0] DECAY_COEF = 32'((Q30_ONE - 64'(NVS_BETA)) << 2);

    typedef enum logic [0:0] {
        REG_SLICE_COUNT,
        REG_RESERVED_SHARES
    } cfg_reg_t;

    typedef logic [SHARE_W-1:0] share_tab_t [0:PCT_FULL];

    // Reserved percent to Q1.30 share, rounded half up.
    function automatic share_tab_t build_share_tab();
        share_tab_t tab;
        for (int i = 0; i <= PCT_FULL; i++)
        begin
            tab[i] = SHARE_W'((64'(i) * Q30_ONE + 64'd50) / 64'd100);
        end
        return tab;
    endfunction

    localparam share_tab_t SHARE_TAB = build_share_tab();

    typedef struct packed {
        logic load;
        logic step;
    } nsw_seq_t;

endpackage

// File: hdl/nsw_div.sv
module nsw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nsw_pkg::nsw_seq_t             seq,
    input  logic [nsw_pkg::SHARE_W-1:0]   share,
    input  logic [nsw_pkg::AVG_W-1:0]     divisor,
    output logic [nsw_pkg::AVG_W-1:0]     quotient
);
    import nsw_pkg::*;

    // Restoring division of share * 2^16 by the average, one quotient bit
    // per step. The caller substitutes a saturated weight in the overflow
    // case; otherwise the partial remainder stays below the divisor.
    logic [AVG_W-1:0] rem_reg;
    logic [AVG_W-1:0] num_reg;
    logic [AVG_W-1:0] quot_reg;
    logic [AVG_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[AVG_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            num_reg  <= '0;
            quot_reg <= '0;
        end
        else if (seq.load)
        begin
            rem_reg  <= AVG_W'(share >> 16);
            num_reg  <= {share[15:0], 16'd0};
            quot_reg <= '0;
        end
        else if (seq.step)
        begin
            rem_reg  <= fits ? AVG_W'(trial - {1'b0, divisor}) : trial[AVG_W-1:0];
            num_reg  <= {num_reg[AVG_W-2:0], 1'b0};
            quot_reg <= {quot_reg[AVG_W-2:0], fits};
        end
    end

    assign quotient = quot_reg;

endmodule

// File: hdl/nsw_decay.sv
module nsw_decay (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nsw_pkg::nsw_seq_t             seq,
    input  logic [nsw_pkg::AVG_W-1:0]     avg,
    output logic [nsw_pkg::AVG_W-1:0]     decayed
);
    import nsw_pkg::*;

    // Shift-add multiply by the constant decay factor, LSB of the factor
    // first. Each step drops one product bit, so after all steps the
    // accumulator holds the floor of the product shifted right by 32.
    logic [AVG_W-1:0] acc_reg;
    logic [AVG_W-1:0] coef_reg;
    logic [AVG_W:0]   sum;

    assign sum = {1'b0, acc_reg} + (coef_reg[0] ? {1'b0, avg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            coef_reg <= '0;
        end
        else if (seq.load)
        begin
            acc_reg  <= '0;
            coef_reg <= DECAY_COEF;
        end
        else if (seq.step)
        begin
            acc_reg  <= sum[AVG_W:1];
            coef_reg <= {1'b0, coef_reg[AVG_W-1:1]};
        end
    end

    assign decayed = acc_reg;

endmodule

// File: hdl/nvs_slice_weight_arbiter_unit.sv
// Each slot decision scans the N effective slices in turn, where N is the
// effective slice count; N = 0 goes straight to the done state.
// A new pending_mask beat is taken only once the previous result has left the done
// state; each slice takes a setup state, the bit-serial divider run and an update state.
// Reset (rst_n, asynchronous, active low): slice_count = 1, shares = 0,
// all averages zero, all started and won flags cleared, no result pending.
module nvs_slice_weight_arbiter_unit #(
    parameter int MAX_SLICES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [nsw_pkg::SHARES_W-1:0]    cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [nsw_pkg::PEND_W-1:0]      pending_mask,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            has_winner,
    output logic [nsw_pkg::WIN_W-1:0]       winner_slice
);
    import nsw_pkg::*;

    localparam int IDX_W  = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int CNT_W  = $clog2(MAX_SLICES + 1) + 1;
    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t                 state_reg;

    // Configuration registers.
    logic [COUNT_W-1:0]     slice_count_reg;
    logic [SHARES_W-1:0]    shares_reg;

    // Per-slice scheduler state. Each entry is read only at the slice
    // currently being scanned.
    logic [AVG_W-1:0]       avg_reg     [MAX_SLICES];
    logic                   won_reg     [MAX_SLICES];
    logic                   started_reg [MAX_SLICES];

    // Scan control and the per-slice working set.
    logic [PEND_W-1:0]      pending_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       slice_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [AVG_W-1:0]       avg_eff_reg;
    logic [SHARE_W-1:0]     share_reg;
    logic [AVG_W-1:0]       best_w_reg;
    logic [IDX_W-1:0]       win_reg;
    logic                   found_reg;

    // Result beat.
    logic                   out_valid_reg;
    logic                   has_winner_reg;
    logic [WIN_W-1:0]       winner_slice_reg;

    // Combinational helpers.
    logic [CNT_W-1:0]       count_next;
    logic [PCT_W-1:0]       pct_raw;
    logic [PCT_W-1:0]       pct;
    logic [SHARE_W-1:0]     share_now;
    logic [AVG_W-1:0]       avg_base;
    logic [AVG_W:0]         avg_boost;
    logic [AVG_W-1:0]       avg_eff_next;
    logic [PEND_W-1:0]      pending_shift;
    logic                   slice_pending;
    logic [AVG_W-1:0]       quotient;
    logic [AVG_W-1:0]       decayed;
    logic [AVG_W-1:0]       weight;
    logic                   last_slice;
    logic                   out_free;
    nsw_seq_t               seq;

    // Slices beyond the count register, or beyond the hardware, sit out.
    assign count_next = (CNT_W'(slice_count_reg) > CNT_W'(MAX_SLICES))
                        ? CNT_W'(MAX_SLICES) : CNT_W'(slice_count_reg);

    // Only the first eight slices have a percent field; the rest get a
    // zero share and therefore never win.
    always_comb
    begin
        if (32'(slice_reg) < (SHARES_W / PCT_W))
        begin
            pct_raw = PCT_W'(shares_reg >> (PCT_W * 32'(slice_reg)));
        end
        else
        begin
            pct_raw = '0;
        end
        pct = (pct_raw > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_raw;
    end

    assign share_now = SHARE_TAB[pct];

    // A slice that is seen for the first time starts from its share; a
    // slice that won the last slot is credited with beta, saturating.
    assign avg_base     = started_reg[slice_reg] ? avg_reg[slice_reg] : AVG_W'(share_now);
    assign avg_boost    = {1'b0, avg_base} + (AVG_W + 1)'(NVS_BETA);
    assign avg_eff_next = won_reg[slice_reg]
                          ? (avg_boost[AVG_W] ? WEIGHT_MAX : avg_boost[AVG_W-1:0])
                          : avg_base;

    assign pending_shift = pending_reg >> slice_reg;
    assign slice_pending = (32'(slice_reg) < PEND_W) && pending_shift[0];

    // A zero share never wins. Otherwise, when share / 2^16 reaches the
    // average (including a zero average) the quotient would not fit in
    // 32 bits and the weight saturates.
    always_comb
    begin
        if (share_reg == '0)
        begin
            weight = '0;
        end
        else if (AVG_W'(share_reg >> 16) >= avg_eff_reg)
        begin
            weight = WEIGHT_MAX;
        end
        else
        begin
            weight = quotient;
        end
    end

    assign last_slice = (CNT_W'(slice_reg) + CNT_W'(1)) == count_reg;
    assign out_free   = !out_valid_reg || out_ready;

    assign seq.load = (state_reg == ST_SETUP);
    assign seq.step = (state_reg == ST_RUN);

    nsw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .seq      (seq),
        .share    (share_now),
        .divisor  (avg_eff_reg),
        .quotient (quotient)
    );

    nsw_decay u_decay (
        .clk      (clk),
        .rst_n    (rst_n),
        .seq      (seq),
        .avg      (avg_eff_reg),
        .decayed  (decayed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slice_count_reg  <= COUNT_W'(1);
            shares_reg       <= '0;
            for (int i = 0; i < MAX_SLICES; i++)
            begin
                avg_reg[i]     <= '0;
                won_reg[i]     <= 1'b0;
                started_reg[i] <= 1'b0;
            end
            pending_reg      <= '0;
            count_reg        <= '0;
            slice_reg        <= '0;
            step_reg         <= '0;
            avg_eff_reg      <= '0;
            share_reg        <= '0;
            best_w_reg       <= '0;
            win_reg          <= '0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            has_winner_reg   <= 1'b0;
            winner_slice_reg <= '0;
        end
        else
        begin
            // Configuration is expected to be written only while the block
            // is idle.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SLICE_COUNT:     slice_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_RESERVED_SHARES: shares_reg      <= cfg_data;
                    default:             ;
                endcase
            end

            // The result register is refilled from the done state once the
            // previous beat has left, and otherwise holds until accepted.
            out_valid_reg <= ((state_reg == ST_DONE) && out_free)
                             || (out_valid_reg && !out_ready);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        pending_reg <= pending_mask;
                        count_reg   <= count_next;
                        slice_reg   <= '0;
                        best_w_reg  <= '0;
                        win_reg     <= '0;
                        found_reg   <= 1'b0;
                        state_reg   <= (count_next == '0) ? ST_DONE : ST_SETUP;
                    end
                end

                ST_SETUP:
                begin
                    share_reg              <= share_now;
                    avg_eff_reg            <= avg_eff_next;
                    started_reg[slice_reg] <= 1'b1;
                    step_reg               <= '0;
                    state_reg              <= ST_RUN;
                end

                ST_RUN:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    avg_reg[slice_reg] <= decayed;
                    won_reg[slice_reg] <= 1'b0;
                    // Strictly greater keeps the lower index on a tie.
                    if (slice_pending && (weight > best_w_reg))
                    begin
                        best_w_reg <= weight;
                        win_reg    <= slice_reg;
                        found_reg  <= 1'b1;
                    end
                    if (last_slice)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        slice_reg <= slice_reg + IDX_W'(1);
                        state_reg <= ST_SETUP;
                    end
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        if (found_reg)
                        begin
                            won_reg[win_reg] <= 1'b1;
                        end
                        has_winner_reg   <= found_reg;
                        winner_slice_reg <= found_reg ? WIN_W'(win_reg) : '0;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign has_winner   = has_winner_reg;
    assign winner_slice = winner_slice_reg;

endmodule
